// ----- rtl/core/assert_macros.svh -----
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion forms used by the checker module.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked assertion that is switched off while reset is high.
`define HED_ASSERT(label, clk, rst, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Clocked assertion that is also checked during reset.
`define HED_ASSERT_ALWAYS(label, clk, prop, msg) \
  label: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ----- rtl/core/hed_pkg.sv -----
// ----------------------------------------------------------------------------
// Haptic envelope driver package
// Opcodes, register map, reset values and fixed-point constants.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package hed_pkg;

  localparam int ENV_DEPTH_DEFAULT = 256;

  // APB address width: six 32-bit registers at byte offsets 0..20.
  localparam int APB_AW = 5;

  typedef enum logic [1:0] {
    OP_TICK  = 2'd0,
    OP_START = 2'd1,
    OP_STOP  = 2'd2,
    OP_WRITE = 2'd3
  } hed_op_t;

  // Register index, taken from paddr[4:2].
  typedef enum logic [2:0] {
    REG_VIB_TYPE   = 3'd0,
    REG_DRIVE_PCT  = 3'd1,
    REG_SPEED_PCT  = 3'd2,
    REG_POINT_DUR  = 3'd3,
    REG_DRIVE_PER  = 3'd4,
    REG_POINT_CNT  = 3'd5
  } hed_reg_t;

  // Level = floor((p * pct * 16 + 625) / 1250), evaluated as
  // (p * pct * LEVEL_RECIP + 2^31) >> 32 with LEVEL_RECIP rounded up.
  localparam int          LEVEL_SHIFT = 32;
  localparam logic [25:0] LEVEL_RECIP = 26'(((64'd16 << LEVEL_SHIFT) / 64'd1250) + 64'd1);

  localparam logic [6:0]  DRIVE_PCT_RESET   = 7'd100;
  localparam logic [5:0]  DRIVE_PER_RESET   = 6'd6;
  localparam logic [32:0] LEVEL_SCALE_RESET = 33'(DRIVE_PCT_RESET) * 33'(LEVEL_RECIP);
  localparam logic [13:0] SPEED_SCALE_RESET = 14'd1000;
  localparam logic [26:0] ADV_THRESH_RESET  = 27'd1000;

endpackage

// ----- rtl/core/hed_ram.sv -----
// ----------------------------------------------------------------------------
// Generic RAM
// One write port and one read port with registered, read-first output.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module hed_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             wr_en,
  input  logic [AW-1:0]    wr_addr,
  input  logic [WIDTH-1:0] wr_data,
  input  logic [AW-1:0]    rd_addr,
  output logic [WIDTH-1:0] rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data <= mem[rd_addr];
  end

endmodule

// ----- rtl/core/haptic_envelope_driver.sv -----
// ----------------------------------------------------------------------------
// Haptic envelope driver
// One vibrator channel: envelope playback, polarity drive and PWM duty output.
// ----------------------------------------------------------------------------
// An item is executed from the input register in a cycle in which it is held
// there and the result queue has room for two more results, and its results
// enter the result queue at the end of that cycle. A new item is taken every
// cycle as long as the four-entry result queue has room for two more results;
// the queue drains one result per cycle while m_tready is high, so items that
// produce two results (motor ticks that advance the envelope while the polarity
// flag is clear) can fill it and hold back the items behind them. The envelope
// entry after the current position is prefetched from the envelope RAM every
// cycle, and entry 0 is mirrored in a register, so a start or an advance never
// waits for the RAM. There is no clearing pass after reset; envelope entries
// read as garbage until they have been written.
`timescale 1ns / 1ps

module haptic_envelope_driver #(
  parameter int ENV_DEPTH = hed_pkg::ENV_DEPTH_DEFAULT
) (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      s_tvalid,
  output logic                      s_tready,
  input  logic [47:0]               s_tdata,   // now_ms[31:0], point_addr[39:32],
                                               // point_level[46:40], zero[47]
  input  logic [1:0]                s_tuser,   // opcode[1:0]
  output logic                      m_tvalid,
  input  logic                      m_tready,
  output logic [15:0]               m_tdata,   // duty_first[7:0], duty_second[15:8]
  output logic                      m_tlast,   // last_of_run
  input  logic                      psel,
  input  logic                      penable,
  input  logic                      pwrite,
  input  logic [hed_pkg::APB_AW-1:0] paddr,
  input  logic [31:0]               pwdata,
  output logic [31:0]               prdata,
  output logic                      pready
);

  import hed_pkg::*;

  localparam int AW     = (ENV_DEPTH > 1) ? $clog2(ENV_DEPTH) : 1;
  localparam int XW     = (AW > 8) ? AW : 8;
  localparam int QDEPTH = 4;

  typedef struct packed {
    logic [7:0] duty_second;
    logic [7:0] duty_first;
    logic       last;
  } res_t;

  // ------------------------------------------------------------------
  // Configuration registers
  // ------------------------------------------------------------------
  logic        vibrator_type;
  logic [6:0]  drive_percent;
  logic [10:0] speed_percent;
  logic [16:0] point_duration_ms;
  logic [5:0]  drive_period_ms;
  logic [8:0]  point_count;
  logic [32:0] level_scale;
  logic [13:0] speed_scale;
  logic [26:0] adv_thresh;

  logic               cfg_we;
  hed_reg_t           cfg_reg;
  logic signed [10:0] spd_in;
  logic signed [10:0] spd_sat;
  logic signed [11:0] spd_factor;
  logic [17:0]        dur_p1;

  assign pready  = 1'b1;
  assign cfg_we  = psel && penable && pwrite;
  assign cfg_reg = hed_reg_t'(paddr[4:2]);
  assign spd_in  = $signed(pwdata[10:0]);
  assign dur_p1  = 18'(pwdata[16:0]) + 18'd1;

  always_comb begin
    if (spd_in < -11'sd99) begin
      spd_sat = -11'sd99;
    end else if (spd_in > 11'sd1000) begin
      spd_sat = 11'sd1000;
    end else begin
      spd_sat = spd_in;
    end
    spd_factor = 12'(spd_sat) + 12'sd100;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vibrator_type     <= 1'b0;
      drive_percent     <= DRIVE_PCT_RESET;
      speed_percent     <= '0;
      point_duration_ms <= '0;
      drive_period_ms   <= DRIVE_PER_RESET;
      point_count       <= '0;
      level_scale       <= LEVEL_SCALE_RESET;
      speed_scale       <= SPEED_SCALE_RESET;
      adv_thresh        <= ADV_THRESH_RESET;
    end else if (cfg_we) begin
      case (cfg_reg)
        REG_VIB_TYPE: begin
          vibrator_type <= pwdata[0];
        end
        REG_DRIVE_PCT: begin
          drive_percent <= pwdata[6:0];
          level_scale   <= 33'(pwdata[6:0]) * 33'(LEVEL_RECIP);
        end
        REG_SPEED_PCT: begin
          speed_percent <= pwdata[10:0];
          speed_scale   <= 14'({spd_factor[10:0], 3'b000}) + 14'({spd_factor[10:0], 1'b0});
        end
        REG_POINT_DUR: begin
          point_duration_ms <= pwdata[16:0];
          // The point advances once the scaled time reaches 1000 * (duration + 1).
          adv_thresh        <= 27'(dur_p1) * 27'd1000;
        end
        REG_DRIVE_PER: begin
          drive_period_ms <= pwdata[5:0];
        end
        REG_POINT_CNT: begin
          point_count <= pwdata[8:0];
        end
        default: begin
        end
      endcase
    end
  end

  always_comb begin
    case (cfg_reg)
      REG_VIB_TYPE:  prdata = 32'(vibrator_type);
      REG_DRIVE_PCT: prdata = 32'(drive_percent);
      REG_SPEED_PCT: prdata = 32'(speed_percent);
      REG_POINT_DUR: prdata = 32'(point_duration_ms);
      REG_DRIVE_PER: prdata = 32'(drive_period_ms);
      REG_POINT_CNT: prdata = 32'(point_count);
      default:       prdata = '0;
    endcase
  end

  // ------------------------------------------------------------------
  // Input register
  // ------------------------------------------------------------------
  logic        in_vld;
  hed_op_t     in_op;
  logic [31:0] in_now;
  logic [7:0]  in_addr;
  logic [6:0]  in_level;
  logic        fire;
  logic [2:0]  q_count;

  assign fire     = in_vld && (q_count <= 3'(QDEPTH - 2));
  assign s_tready = !in_vld || fire;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_vld <= 1'b0;
    end else begin
      in_vld <= (s_tvalid && s_tready) || (in_vld && !fire);
    end
  end

  always_ff @(posedge clk) begin
    if (s_tvalid && s_tready) begin
      in_op    <= hed_op_t'(s_tuser);
      in_now   <= s_tdata[31:0];
      in_addr  <= s_tdata[39:32];
      in_level <= s_tdata[46:40];
    end
  end

  // ------------------------------------------------------------------
  // Channel state and envelope store
  // ------------------------------------------------------------------
  logic          playing,        playing_next;
  logic          polarity_flag,  polarity_flag_next;
  logic [31:0]   cycle_start,    cycle_start_next;
  logic [31:0]   point_start,    point_start_next;
  logic [AW-1:0] point_pos,      point_pos_next;
  logic [7:0]    drive_level,    drive_level_next;

  logic [6:0]    entry0;
  logic          byp_hit;
  logic [6:0]    byp_data;
  logic          wr_en;
  logic [AW-1:0] wr_idx;
  logic [AW-1:0] pf_addr;
  logic [6:0]    pf_raw;
  logic [XW-1:0] addr_ext;
  logic          addr_ok;

  hed_ram #(
    .WIDTH (7),
    .DEPTH (ENV_DEPTH)
  ) u_env_ram (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (wr_idx),
    .wr_data (in_level),
    .rd_addr (pf_addr),
    .rd_data (pf_raw)
  );

  assign addr_ext = XW'(in_addr);
  assign wr_idx   = addr_ext[AW-1:0];
  assign addr_ok  = 32'(in_addr) < 32'(ENV_DEPTH);
  assign wr_en    = fire && (in_op == OP_WRITE) && addr_ok;

  // Prefetch the entry after the position that holds from the next cycle on.
  logic [AW:0] pf_inc;
  assign pf_inc  = {1'b0, (fire ? point_pos_next : point_pos)} + (AW + 1)'(1);
  assign pf_addr = (32'(pf_inc) >= 32'(ENV_DEPTH)) ? '0 : pf_inc[AW-1:0];

  always_ff @(posedge clk) begin
    if (rst) begin
      byp_hit <= 1'b0;
    end else begin
      // The RAM reads old data when written and read at one address together.
      byp_hit <= wr_en && (wr_idx == pf_addr);
    end
  end

  always_ff @(posedge clk) begin
    byp_data <= in_level;
    if (wr_en && (wr_idx == '0)) begin
      entry0 <= in_level;
    end
  end

  // ------------------------------------------------------------------
  // Execute
  // ------------------------------------------------------------------
  logic [AW:0]        pos_inc;
  logic               wrap;
  logic [AW-1:0]      adv_pos;
  logic [6:0]         level_src;
  logic [40:0]        level_prod;
  logic [8:0]         level_raw;
  logic [7:0]         new_level;
  logic signed [31:0] cyc_el;
  logic signed [31:0] pt_el;
  logic               c_le_half;
  logic               c_le_per;
  logic signed [47:0] adv_num;
  logic               advance;
  logic [8:0]         lvl9;
  logic [8:0]         hi9;
  logic [8:0]         lo9;
  logic [8:0]         dbl9;
  logic [7:0]         dbl;
  res_t               res [2];
  logic [1:0]         n_res;

  assign pos_inc   = {1'b0, point_pos} + (AW + 1)'(1);
  assign wrap      = (32'(pos_inc) >= 32'(point_count)) || (32'(pos_inc) >= 32'(ENV_DEPTH));
  assign adv_pos   = wrap ? '0 : pos_inc[AW-1:0];
  assign level_src = ((in_op == OP_START) || wrap) ? entry0 : (byp_hit ? byp_data : pf_raw);

  assign level_prod = 41'(level_src) * 41'(level_scale) + (41'd1 << (LEVEL_SHIFT - 1));
  assign level_raw  = level_prod[LEVEL_SHIFT +: 9];
  assign new_level  = (level_raw > 9'd128) ? 8'd128 : level_raw[7:0];

  assign cyc_el    = $signed(in_now - cycle_start);
  assign pt_el     = $signed(in_now - point_start);
  assign c_le_half = cyc_el <= $signed(32'(drive_period_ms[5:1]));
  assign c_le_per  = cyc_el <= $signed(32'(drive_period_ms));
  assign adv_num   = pt_el * $signed({1'b0, speed_scale}) + 48'sd499;
  assign advance   = adv_num >= $signed(48'(adv_thresh));

  assign lvl9 = {1'b0, drive_level};
  assign hi9  = 9'd127 + lvl9;
  assign lo9  = 9'd128 - lvl9;
  assign dbl9 = {new_level, 1'b0};
  assign dbl  = (dbl9 > 9'd255) ? 8'd255 : dbl9[7:0];

  always_comb begin
    playing_next       = playing;
    polarity_flag_next = polarity_flag;
    cycle_start_next   = cycle_start;
    point_start_next   = point_start;
    point_pos_next     = point_pos;
    drive_level_next   = drive_level;
    res[0]             = '0;
    res[1]             = '0;
    n_res              = 2'd0;

    case (in_op)
      OP_TICK: begin
        if (playing) begin
          if (!vibrator_type) begin
            if (c_le_half) begin
              if (polarity_flag) begin
                polarity_flag_next = 1'b0;
                res[n_res[0]]      = '{duty_second: lo9[7:0], duty_first: hi9[7:0], last: 1'b0};
                n_res              = n_res + 2'd1;
              end
            end else if (c_le_per) begin
              if (!polarity_flag) begin
                polarity_flag_next = 1'b1;
                res[n_res[0]]      = '{duty_second: hi9[7:0], duty_first: lo9[7:0], last: 1'b0};
                n_res              = n_res + 2'd1;
              end
            end else begin
              cycle_start_next = in_now;
            end
          end else if (!polarity_flag) begin
            polarity_flag_next = 1'b1;
            res[n_res[0]]      = '{duty_second: lo9[7:0], duty_first: hi9[7:0], last: 1'b0};
            n_res              = n_res + 2'd1;
          end

          if (advance) begin
            point_pos_next   = adv_pos;
            drive_level_next = new_level;
            point_start_next = in_now;
            if (vibrator_type) begin
              res[n_res[0]] = '{duty_second: dbl, duty_first: dbl, last: 1'b0};
              n_res         = n_res + 2'd1;
            end
          end
        end
      end
      OP_START: begin
        if (point_count == '0) begin
          playing_next = 1'b0;
        end else begin
          playing_next       = 1'b1;
          drive_level_next   = new_level;
          cycle_start_next   = in_now;
          point_start_next   = in_now;
          polarity_flag_next = 1'b0;
          point_pos_next     = '0;
        end
      end
      OP_STOP: begin
        playing_next = 1'b0;
        res[0]       = '{duty_second: 8'd0, duty_first: 8'd0, last: 1'b0};
        n_res        = 2'd1;
      end
      default: begin
      end
    endcase

    if (n_res == 2'd2) begin
      res[1].last = 1'b1;
    end else if (n_res == 2'd1) begin
      res[0].last = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      playing       <= 1'b0;
      polarity_flag <= 1'b0;
      cycle_start   <= '0;
      point_start   <= '0;
      point_pos     <= '0;
      drive_level   <= '0;
    end else if (fire) begin
      playing       <= playing_next;
      polarity_flag <= polarity_flag_next;
      cycle_start   <= cycle_start_next;
      point_start   <= point_start_next;
      point_pos     <= point_pos_next;
      drive_level   <= drive_level_next;
    end
  end

  // ------------------------------------------------------------------
  // Result queue
  // ------------------------------------------------------------------
  res_t       q [QDEPTH];
  logic [1:0] q_wr;
  logic [1:0] q_rd;
  logic [1:0] n_push;
  logic       pop;

  assign n_push   = fire ? n_res : 2'd0;
  assign m_tvalid = (q_count != 3'd0);
  assign pop      = m_tvalid && m_tready;
  assign m_tdata  = {q[q_rd].duty_second, q[q_rd].duty_first};
  assign m_tlast  = q[q_rd].last;

  always_ff @(posedge clk) begin
    if (rst) begin
      q_wr    <= '0;
      q_rd    <= '0;
      q_count <= '0;
    end else begin
      q_wr    <= q_wr + n_push;
      q_rd    <= q_rd + 2'(pop);
      q_count <= q_count + 3'(n_push) - 3'(pop);
    end
  end

  always_ff @(posedge clk) begin
    if (n_push != 2'd0) begin
      q[q_wr] <= res[0];
    end
    if (n_push == 2'd2) begin
      q[q_wr + 2'd1] <= res[1];
    end
  end

endmodule

// ----- rtl/core/hed_checker.sv -----
// ----------------------------------------------------------------------------
// Haptic envelope driver checker
// Port-level assertions on results and register readback, bound to the top.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "assert_macros.svh"

module hed_checker (
  input logic                       clk,
  input logic                       rst,
  input logic                       m_tvalid,
  input logic                       m_tready,
  input logic [15:0]                m_tdata,
  input logic                       m_tlast,
  input logic                       psel,
  input logic                       penable,
  input logic                       pwrite,
  input logic [hed_pkg::APB_AW-1:0] paddr,
  input logic [31:0]                pwdata,
  input logic [31:0]                prdata
);

  import hed_pkg::*;

  // Reset empties the result queue.
  `HED_ASSERT_ALWAYS(a_reset_empty, clk, rst |=> !m_tvalid, "result valid after reset")

  // Polarity writes are complementary; DC and stop writes drive both outputs alike.
  `HED_ASSERT(a_duty_pair, clk, rst, (m_tvalid && m_tdata[7:0] != m_tdata[15:8]) |-> (9'(m_tdata[7:0]) + 9'(m_tdata[15:8]) == 9'd255), "duty pair is neither equal nor complementary")

  // An all-zero duty pair only comes from stop or a motor advance, both final.
  `HED_ASSERT(a_zero_last, clk, rst, (m_tvalid && m_tdata == 16'h0000) |-> m_tlast, "zero duty pair not marked last")

  `HED_ASSERT(a_out_hold, clk, rst, (m_tvalid && !m_tready) |=> (m_tvalid && $stable(m_tdata) && $stable(m_tlast)), "stalled result changed")

  // A drive percent write reads back masked to its field width.
  `HED_ASSERT(a_pct_readback, clk, rst, (psel && penable && pwrite && paddr[4:2] == REG_DRIVE_PCT) |=> (paddr[4:2] != REG_DRIVE_PCT || prdata == ($past(pwdata) & 32'h0000007f)), "drive percent readback mismatch")

endmodule

bind haptic_envelope_driver hed_checker u_hed_checker (.*);
